FILE: hw/rtl/spq_pkg.sv
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Depth, field widths, status and operation codes, memory word layout.
// ----------------------------------------------------------------------------
package spq_pkg;
  localparam int unsigned QueueDepth = 16;
  localparam int unsigned AddrW      = $clog2(QueueDepth);
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned PrioW      = 8;
  localparam int unsigned IdW        = 16;

  localparam logic       OP_INSERT = 1'b0;
  localparam logic       OP_REMOVE = 1'b1;
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  typedef struct packed {
    logic [PrioW-1:0] prio;
    logic [IdW-1:0]   id;
  } entry_t;

  // First member lands in the top bits, so removed_id sits at bit 0.
  typedef struct packed {
    logic [1:0]       status;
    logic             is_empty;
    logic [PrioW-1:0] head_priority;
    logic [IdW-1:0]   head_id;
    logic [IdW-1:0]   removed_id;
  } result_t;
endpackage

FILE: hw/rtl/spq_ram.sv
// ----------------------------------------------------------------------------
// spq_ram: entry store
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module spq_ram (
  input  logic                   clk,
  input  logic                   we,
  input  logic [spq_pkg::AddrW-1:0] waddr,
  input  spq_pkg::entry_t        wdata,
  input  logic [spq_pkg::AddrW-1:0] raddr,
  output spq_pkg::entry_t        rdata
);
  spq_pkg::entry_t mem [spq_pkg::QueueDepth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/stable_priority_queue.sv
// ----------------------------------------------------------------------------
// stable_priority_queue: bounded sorted priority queue
// Insert goes behind all entries of equal or higher priority; remove takes
// the head. Each transfer in yields one result with head, empty and status.
// ----------------------------------------------------------------------------
// channel | dir | handshake                 | payload
// in_     | in  | in_tvalid / in_tready     | in_tdata: op, priority, id
// out_    | out | out_tvalid / out_tready   | out_tdata: result fields
//
// Entries live in one RAM, sorted, head at address 0. An insert walks from
// the tail toward the head, one entry per cycle, moving each lower-priority
// entry back a slot, then writes the new item into the freed slot. A remove
// walks from the head toward the tail, moving every later entry forward a
// slot; full inserts and empty removes move nothing. in_tready returns the
// cycle after the result is formed. Reset clears control state only; slots
// beyond the occupancy never reach a result. A result not yet taken holds
// the next one in its final state until out_tready frees the output
// register.
module stable_priority_queue (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [0] operation, [8:1] priority_req,
                                  // [24:9] item_id, [31:25] zero
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // [15:0] removed_id, [31:16] head_id,
                                  // [39:32] head_priority, [40] is_empty,
                                  // [42:41] status, [47:43] zero
);
  localparam int unsigned AW = spq_pkg::AddrW;
  localparam int unsigned CW = spq_pkg::CountW;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INS   = 3'd1;  // walk tail toward head
  localparam logic [2:0] S_PLACE = 3'd2;  // write new item into the head slot
  localparam logic [2:0] S_REM   = 3'd3;  // walk head toward tail
  localparam logic [2:0] S_HEAD  = 3'd4;  // read head after update
  localparam logic [2:0] S_DONE  = 3'd5;  // head data is back, form result

  logic [2:0]                state_r, state_nxt;
  logic [CW-1:0]             occ_r, occ_nxt;
  logic [CW-1:0]             pidx_r, pidx_nxt;  // slot whose read data is back
  logic [spq_pkg::PrioW-1:0] prio_r, prio_nxt;
  logic [spq_pkg::IdW-1:0]   id_r, id_nxt;
  logic [spq_pkg::IdW-1:0]   removed_r, removed_nxt;
  logic [1:0]                status_r, status_nxt;
  spq_pkg::result_t          res_r, res_nxt;
  logic                      ovalid_r, ovalid_nxt;
  logic                      load_res;

  logic            we;
  logic [AW-1:0]   waddr, raddr;
  spq_pkg::entry_t wdata, rdata;

  spq_ram u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
    .raddr(raddr), .rdata(rdata)
  );

  wire accept = in_tvalid && in_tready;
  wire in_op  = in_tdata[0];

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'd0, res_r};

  always_comb begin
    state_nxt   = state_r;
    occ_nxt     = occ_r;
    pidx_nxt    = pidx_r;
    prio_nxt    = prio_r;
    id_nxt      = id_r;
    removed_nxt = removed_r;
    status_nxt  = status_r;
    res_nxt     = res_r;
    load_res    = 1'b0;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '{prio: prio_r, id: id_r};
    raddr       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          prio_nxt    = in_tdata[8:1];
          id_nxt      = in_tdata[24:9];
          removed_nxt = '0;
          status_nxt  = spq_pkg::ST_OK;
          if (in_op == spq_pkg::OP_INSERT) begin
            if (occ_r == CW'(spq_pkg::QueueDepth)) begin
              status_nxt = spq_pkg::ST_FULL;
              state_nxt  = S_HEAD;
            end else if (occ_r == '0) begin
              state_nxt = S_PLACE;
            end else begin
              // Start at the tail.
              raddr     = AW'(occ_r - 1'b1);
              pidx_nxt  = occ_r - 1'b1;
              state_nxt = S_INS;
            end
          end else begin
            if (occ_r == '0) begin
              status_nxt = spq_pkg::ST_EMPTY;
              state_nxt  = S_HEAD;
            end else begin
              raddr     = '0;
              pidx_nxt  = '0;
              state_nxt = S_REM;
            end
          end
        end
      end
      S_INS: begin
        // Move a lower-priority entry back one slot, or drop the new item
        // in right behind an entry of equal or higher priority.
        we    = 1'b1;
        waddr = AW'(pidx_r + 1'b1);
        if (rdata.prio < prio_r) begin
          wdata = rdata;
          if (pidx_r == '0) begin
            state_nxt = S_PLACE;
          end else begin
            raddr    = AW'(pidx_r - 1'b1);
            pidx_nxt = pidx_r - 1'b1;
          end
        end else begin
          occ_nxt   = occ_r + 1'b1;
          state_nxt = S_HEAD;
        end
      end
      S_PLACE: begin
        we        = 1'b1;
        waddr     = '0;
        occ_nxt   = occ_r + 1'b1;
        state_nxt = S_HEAD;
      end
      S_REM: begin
        // Slot 0 is the removed item; every later slot advances by one.
        if (pidx_r == '0) begin
          removed_nxt = rdata.id;
        end else begin
          we    = 1'b1;
          waddr = AW'(pidx_r - 1'b1);
          wdata = rdata;
        end
        if ((pidx_r + 1'b1) < occ_r) begin
          raddr    = AW'(pidx_r + 1'b1);
          pidx_nxt = pidx_r + 1'b1;
        end else begin
          occ_nxt   = occ_r - 1'b1;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        raddr     = '0;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        // Keep reading the head so the data holds while the output is busy.
        raddr = '0;
        if (!ovalid_r || out_tready) begin
          load_res              = 1'b1;
          res_nxt.removed_id    = removed_r;
          res_nxt.status        = status_r;
          res_nxt.is_empty      = (occ_r == '0);
          res_nxt.head_id       = (occ_r == '0) ? '0 : rdata.id;
          res_nxt.head_priority = (occ_r == '0) ? '0 : rdata.prio;
          state_nxt             = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (load_res) begin
      ovalid_nxt = 1'b1;
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      occ_r     <= '0;
      pidx_r    <= '0;
      prio_r    <= '0;
      id_r      <= '0;
      removed_r <= '0;
      status_r  <= spq_pkg::ST_OK;
      res_r     <= '0;
      ovalid_r  <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      occ_r     <= occ_nxt;
      pidx_r    <= pidx_nxt;
      prio_r    <= prio_nxt;
      id_r      <= id_nxt;
      removed_r <= removed_nxt;
      status_r  <= status_nxt;
      res_r     <= res_nxt;
      ovalid_r  <= ovalid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_rdy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> state_r == S_IDLE) else $error("ready outside idle");
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(spq_pkg::QueueDepth)) else $error("occupancy overflow");
  a_res: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> out_tvalid) else $error("result lost");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> (out_tvalid && $stable(out_tdata)))
    else $error("result changed while stalled");
`endif
endmodule

FILE: sim/stable_priority_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_checker: result predictor and comparator
// Watches both stream channels, keeps its own sorted copy of the queue and
// checks every result transfer against the oldest predicted result.
// ----------------------------------------------------------------------------
module stable_priority_queue_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [47:0] out_tdata,
  output int          fail_count,
  output int          pending_count,
  output int          full_count,
  output int          empty_count
);
  spq_pkg::entry_t   shadow_q[$];
  spq_pkg::result_t  pending_results[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %0h want %0h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  function automatic spq_pkg::result_t predict_step(input logic [31:0] word);
    spq_pkg::result_t r;
    spq_pkg::entry_t  e;
    int               pos;
    r = '0;
    r.status = spq_pkg::ST_OK;
    if (word[0] == spq_pkg::OP_INSERT) begin
      if (shadow_q.size() >= spq_pkg::QueueDepth) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        e.prio = word[8:1];
        e.id   = word[24:9];
        pos = 0;
        // ties go behind older entries
        while (pos < shadow_q.size() && shadow_q[pos].prio >= e.prio) pos++;
        shadow_q.insert(pos, e);
      end
    end else begin
      if (shadow_q.size() == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.removed_id = shadow_q[0].id;
        void'(shadow_q.pop_front());
      end
    end
    if (shadow_q.size() > 0) begin
      r.head_id       = shadow_q[0].id;
      r.head_priority = shadow_q[0].prio;
    end else begin
      r.is_empty = 1'b1;
    end
    return r;
  endfunction

  initial pending_count = 0;

  always @(posedge clk) begin
    spq_pkg::result_t want;
    spq_pkg::result_t got;
    if (!rst_n) begin
      fail_count  = 0;
      full_count  = 0;
      empty_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        got = out_tdata[42:0];
        if (pending_results.size() == 0) begin
          report("unexpected result", out_tdata[31:0], 0);
        end else begin
          want = pending_results.pop_front();
          if (got.removed_id != want.removed_id) report("removed_id", got.removed_id, want.removed_id);
          if (got.head_id != want.head_id) report("head_id", got.head_id, want.head_id);
          if (got.head_priority != want.head_priority)
            report("head_priority", got.head_priority, want.head_priority);
          if (got.is_empty != want.is_empty) report("is_empty", got.is_empty, want.is_empty);
          if (got.status != want.status) report("status", got.status, want.status);
        end
      end
      if (in_tvalid && in_tready) begin
        want = predict_step(in_tdata);
        if (want.status == spq_pkg::ST_FULL) full_count++;
        if (want.status == spq_pkg::ST_EMPTY) empty_count++;
        pending_results.push_back(want);
      end
    end
    pending_count = pending_results.size();
  end
endmodule

FILE: sim/stable_priority_queue_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_tb: stimulus and verdict for the sorted queue
// Directed corner items, then random insert/remove mixes with random gaps on
// both channels and one long output hold-off that backs up the input.
// ----------------------------------------------------------------------------
module stable_priority_queue_tb;
  localparam int RandomItems = 1300;
  localparam int CycleLimit  = 400000;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [0] operation, [8:1] priority_req, [24:9] item_id
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // [15:0] removed_id, [31:16] head_id,
                           // [39:32] head_priority, [40] is_empty, [42:41] status
  int          fail_count;
  int          pending_count;
  int          full_count;
  int          empty_count;
  int          cycle_count;
  int          sent_count;
  logic        hold_off;
  logic        stim_done;

  stable_priority_queue dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  stable_priority_queue_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .fail_count(fail_count), .pending_count(pending_count),
    .full_count(full_count), .empty_count(empty_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Global watchdog: count cycles and bail out if the run hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one item and hold it until the transfer happens. The valid is only
  // lowered when a gap follows, so back-to-back items keep it high.
  task automatic send_item(input logic op, input logic [7:0] prio, input logic [15:0] id);
    int gap;
    gap = hold_off ? 0 : $urandom_range(0, 16);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, id, prio, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_count++;
  endtask

  // Receiver: random stall per result, plus one long hold-off while the
  // sender keeps offering so the output backs up and input stalls.
  initial begin
    int wait_cycles;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
      end
      wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
      if (sent_count > 900) wait_cycles = 0;
      if (wait_cycles > 0) begin
        out_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  initial begin
    int fill_bias;
    logic op;
    cycle_count = 0;
    sent_count  = 0;
    hold_off    = 1'b0;
    stim_done   = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: remove on empty, extreme fields, ties, full insert, drain.
    send_item(spq_pkg::OP_REMOVE, 8'hFF, 16'hFFFF);
    send_item(spq_pkg::OP_INSERT, 8'h00, 16'h0000);
    send_item(spq_pkg::OP_INSERT, 8'hFF, 16'hFFFF);
    send_item(spq_pkg::OP_INSERT, 8'h80, 16'h1234);
    send_item(spq_pkg::OP_INSERT, 8'h80, 16'h5678);  // tie stays behind the older one
    send_item(spq_pkg::OP_INSERT, 8'hFF, 16'hAAAA);
    send_item(spq_pkg::OP_INSERT, 8'h00, 16'h5555);
    for (int i = 0; i < 11; i++) send_item(spq_pkg::OP_INSERT, 8'(i * 23), 16'(i));
    send_item(spq_pkg::OP_INSERT, 8'h7F, 16'hBEEF);  // rejected: queue full
    for (int i = 0; i < 17; i++) send_item(spq_pkg::OP_REMOVE, 8'(i), 16'hFFFF);

    // Random: phases biased toward filling or draining so both the full and
    // the empty edges are visited often, with random content throughout.
    for (int i = 0; i < RandomItems; i++) begin
      if (i % 60 == 0) fill_bias = $urandom_range(20, 80);
      if (i == 300) hold_off <= 1'b1;
      op = ($urandom_range(1, 100) > fill_bias) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
      // narrow priority range now and then to provoke many ties
      send_item(op, ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3)) : 8'($urandom),
                16'($urandom));
    end
    in_tvalid <= 1'b0;
    stim_done <= 1'b1;

    while (pending_count != 0) @(posedge clk);
    repeat (spq_pkg::QueueDepth + 8) @(posedge clk);
    $display("covered %0d items: %0d full-queue rejects, %0d empty removes",
             sent_count, full_count, empty_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
